@@ hw/rtl/mlc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MESI LRU data cache tags package
// Shared types, codes and default sizes for the cache tag store.
// ----------------------------------------------------------------------------
package mlc_pkg;

   localparam int WAYS_DEF        = 8;
   localparam int OFFSET_BITS_DEF = 6;
   localparam int INDEX_BITS_DEF  = 14;

   typedef enum logic [1:0] {
      MODE_READ       = 2'd0,
      MODE_WRITE      = 2'd1,
      MODE_INVALIDATE = 2'd2,
      MODE_SNOOP      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      MESI_I = 2'd0,
      MESI_S = 2'd1,
      MESI_E = 2'd2,
      MESI_M = 2'd3
   } mesi_type;

   typedef enum logic [1:0] {
      CTRL_IDLE   = 2'd0,
      CTRL_LOOKUP = 2'd1,
      CTRL_UPDATE = 2'd2
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic lookup;
      logic update;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } status_type;

   // One result beat.
   typedef struct packed {
      logic [31:0] miss_total;
      logic [31:0] hit_total;
      logic [31:0] write_total;
      logic [31:0] read_total;
      logic        snoop_data_return;
      logic        l2_write_back;
      logic        l2_write_through;
      logic        l2_read_for_ownership;
      logic        l2_read;
      mesi_type    line_state;
      logic [2:0]  way;
      logic        hit;
   } rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/mlc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MESI LRU data cache tags controller
// Sequences each beat through lookup and update of the tag store.
// ----------------------------------------------------------------------------
module mlc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire mlc_pkg::status_type status,
   output mlc_pkg::cmd_type        cmd
);
   import mlc_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (req_tvalid) state_in = CTRL_LOOKUP;
         end
         CTRL_LOOKUP: begin
            state_in = CTRL_UPDATE;
         end
         CTRL_UPDATE: begin
            // The next beat may enter as this one retires.
            if (!status.out_busy) begin
               state_in = req_tvalid ? CTRL_LOOKUP : CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         CTRL_IDLE: begin
            req_tready = 1'b1;
         end
         CTRL_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         CTRL_UPDATE: begin
            req_tready = !status.out_busy;
            cmd.update = !status.out_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.load = req_tready && req_tvalid;
   end

endmodule
`default_nettype wire

@@ hw/rtl/mlc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MESI LRU data cache tags datapath
// Tag store, way match and victim choice, MESI and age update, counters
// and the result register.
// ----------------------------------------------------------------------------
module mlc_datapath #(
   parameter int WAYS        = mlc_pkg::WAYS_DEF,
   parameter int OFFSET_BITS = mlc_pkg::OFFSET_BITS_DEF,
   parameter int INDEX_BITS  = mlc_pkg::INDEX_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mlc_pkg::cmd_type    cmd,
   output mlc_pkg::status_type      status,
   input  wire logic [1:0]          req_mode,
   input  wire logic [31:0]         req_address,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output mlc_pkg::rsp_type         rsp
);
   import mlc_pkg::*;

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_W = WAY_W;
   localparam int SHIFT = OFFSET_BITS + INDEX_BITS;
   localparam int TAG_W = (SHIFT < 32) ? 32 - SHIFT : 1;
   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

   // Tag store.
   logic [TAG_W-1:0] way_tag_ff    [WAYS];
   logic             way_filled_ff [WAYS];
   mesi_type         way_mesi_ff   [WAYS];
   logic [AGE_W-1:0] way_age_ff    [WAYS];
   logic [AGE_W-1:0] way_age_in    [WAYS];

   // Item being worked on.
   mode_type         mode_ff;
   logic [TAG_W-1:0] tag_ff;

   // Lookup results.
   logic             hit_ff,  hit_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [WAY_W-1:0] victim_ff, victim_in;
   logic             vic_unfilled_ff, vic_unfilled_in;
   logic             vic_evict_ff, vic_evict_in;

   logic [31:0] read_ff, read_in;
   logic [31:0] write_ff, write_in;
   logic [31:0] hits_ff, hits_in;
   logic [31:0] miss_ff, miss_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic             is_rw, is_wr;
   logic [WAY_W-1:0] sel;
   mesi_type         cur_st, new_st;
   logic [AGE_W-1:0] sel_age;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode_type'(req_mode);
         tag_ff  <= TAG_W'(req_address >> SHIFT);
      end
   end

   // Way match and victim choice over the stored ways.
   always_comb begin
      logic any_unf, any_inv, any_old;
      logic [WAY_W-1:0] first_unf, first_inv, first_old;
      hit_in    = 1'b0;
      hit_way_in = '0;
      any_unf   = 1'b0;
      any_inv   = 1'b0;
      any_old   = 1'b0;
      first_unf = '0;
      first_inv = '0;
      first_old = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (way_filled_ff[i] && (way_tag_ff[i] == tag_ff)) begin
            hit_in     = 1'b1;
            hit_way_in = WAY_W'(i);
         end
         if (!way_filled_ff[i]) begin
            any_unf   = 1'b1;
            first_unf = WAY_W'(i);
         end
         if (way_mesi_ff[i] == MESI_I) begin
            any_inv   = 1'b1;
            first_inv = WAY_W'(i);
         end
         if (way_age_ff[i] == AGE_OLDEST) begin
            any_old   = 1'b1;
            first_old = WAY_W'(i);
         end
      end
      vic_unfilled_in = 1'b0;
      vic_evict_in    = 1'b0;
      if (any_unf) begin
         victim_in       = first_unf;
         vic_unfilled_in = 1'b1;
      end else if (any_inv) begin
         victim_in = first_inv;
      end else begin
         victim_in    = any_old ? first_old : '0;
         vic_evict_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff          <= hit_in;
         hit_way_ff      <= hit_way_in;
         victim_ff       <= victim_in;
         vic_unfilled_ff <= vic_unfilled_in;
         vic_evict_ff    <= vic_evict_in;
      end
   end

   // State update and result.
   always_comb begin
      is_wr   = (mode_ff == MODE_WRITE);
      is_rw   = (mode_ff == MODE_READ) || is_wr;
      sel     = (is_rw && !hit_ff) ? victim_ff : hit_way_ff;
      cur_st  = way_mesi_ff[sel];
      sel_age = way_age_ff[sel];

      new_st = MESI_I;
      if (is_rw) begin
         if (!hit_ff) begin
            new_st = is_wr ? MESI_M : MESI_E;
         end else if (is_wr) begin
            new_st = (cur_st == MESI_M || cur_st == MESI_E) ? MESI_M : MESI_E;
         end else begin
            new_st = (cur_st == MESI_M) ? MESI_M : MESI_S;
         end
      end

      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) == sel) begin
            way_age_in[i] = '0;
         end else if (way_age_ff[i] <= sel_age) begin
            way_age_in[i] = way_age_ff[i] + AGE_W'(1);
         end else begin
            way_age_in[i] = way_age_ff[i];
         end
      end

      read_in  = read_ff  + ((mode_ff == MODE_READ) ? 32'd1 : 32'd0);
      write_in = write_ff + (is_wr ? 32'd1 : 32'd0);
      hits_in  = hits_ff  + ((is_rw && hit_ff) ? 32'd1 : 32'd0);
      miss_in  = miss_ff  + ((is_rw && !hit_ff) ? 32'd1 : 32'd0);

      rsp_in.hit                   = hit_ff;
      rsp_in.way                   = (is_rw || hit_ff) ? 3'(sel) : 3'd0;
      rsp_in.line_state            = new_st;
      rsp_in.l2_read               = is_rw && !hit_ff && !is_wr;
      rsp_in.l2_read_for_ownership = is_wr && !hit_ff && !vic_unfilled_ff;
      rsp_in.l2_write_through      = is_wr && !hit_ff && vic_unfilled_ff;
      rsp_in.l2_write_back         = is_wr && !hit_ff && vic_evict_ff;
      rsp_in.snoop_data_return     = (mode_ff == MODE_SNOOP) && hit_ff &&
                                     (cur_st != MESI_I);
      rsp_in.read_total            = read_in;
      rsp_in.write_total           = write_in;
      rsp_in.hit_total             = hits_in;
      rsp_in.miss_total            = miss_in;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.update) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAYS; i++) begin
            way_filled_ff[i] <= 1'b0;
            way_mesi_ff[i]   <= MESI_I;
            way_age_ff[i]    <= '0;
         end
         read_ff      <= '0;
         write_ff     <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.update) begin
            read_ff  <= read_in;
            write_ff <= write_in;
            hits_ff  <= hits_in;
            miss_ff  <= miss_in;
            if (is_rw) begin
               way_filled_ff[sel] <= 1'b1;
               way_mesi_ff[sel]   <= new_st;
               for (int i = 0; i < WAYS; i++) begin
                  way_age_ff[i] <= way_age_in[i];
               end
            end else if (hit_ff) begin
               way_mesi_ff[sel] <= MESI_I;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_ff <= rsp_in;
         if (is_rw && !hit_ff) way_tag_ff[sel] <= tag_ff;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;

endmodule
`default_nettype wire

@@ hw/rtl/mesi_lru_data_cache_tags_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MESI LRU data cache tags
// Fully associative tag store with MESI line states and true LRU ages.
// ----------------------------------------------------------------------------
// Each request beat carries an access kind in req_tuser (read, write,
// invalidate or snoop) and a byte address in req_tdata. For every request
// one response beat returns hit, way, new line state, the L2 action flags
// and the running read, write, hit and miss counters.
// An accepted beat is registered, then passes the lookup step (way match
// and victim choice) and the update step (tag, state and age update),
// after which its response is valid; the update step waits while a
// response is held. Each request makes the lookup then update passes over
// the shared tag store; the next request is accepted in the cycle in which
// the current one retires.
// Reset clears all ways to unfilled and invalid, all ages and counters to
// zero; the block is ready in the first cycle after reset.
// When the receiver stalls, the response is held in the output register;
// one more request is accepted and looked up, and it then waits in the
// update step until the pending response is taken.
// ----------------------------------------------------------------------------
module mesi_lru_data_cache_tags_top #(
   parameter int WAYS        = mlc_pkg::WAYS_DEF,
   parameter int OFFSET_BITS = mlc_pkg::OFFSET_BITS_DEF,
   parameter int INDEX_BITS  = mlc_pkg::INDEX_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [31:0] address
   input  wire logic [1:0]   req_tuser,   // [1:0] mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [0] hit, [3:1] way, [5:4] line_state, [6] l2_read,
   // [7] l2_read_for_ownership, [8] l2_write_through, [9] l2_write_back,
   // [10] snoop_data_return, [42:11] read_total, [74:43] write_total,
   // [106:75] hit_total, [138:107] miss_total, [143:139] zero
   output logic [143:0]      rsp_tdata
);
   import mlc_pkg::*;

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp;

   mlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mlc_datapath #(
      .WAYS        (WAYS),
      .OFFSET_BITS (OFFSET_BITS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_mode    (req_tuser),
      .req_address (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.miss_total, rsp.hit_total, rsp.write_total,
                       rsp.read_total, rsp.snoop_data_return, rsp.l2_write_back,
                       rsp.l2_write_through, rsp.l2_read_for_ownership,
                       rsp.l2_read, rsp.line_state, rsp.way, rsp.hit};

endmodule
`default_nettype wire

@@ test/mesi_lru_data_cache_tags_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MESI LRU data cache tags testbench
// Drives reads, writes, invalidates and snoops into the tag store and checks
// every response beat against a cycle-free model of the ways, MESI states,
// LRU ages and counters, under several patterns of source and sink stalls.
// ----------------------------------------------------------------------------
module mesi_lru_data_cache_tags_top_tb;
   import mlc_pkg::*;

   localparam int TAG_SHIFT      = OFFSET_BITS_DEF + INDEX_BITS_DEF;
   localparam int TAG_W          = 32 - TAG_SHIFT;
   localparam int PHASE_ACCESSES = 385;
   localparam int HOLD_CYCLES    = 150;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int POOL_SIZE      = 12;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] address;
   } access_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;   // [31:0] address
   logic [1:0]   req_tuser = MODE_READ;   // [1:0] mode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [0] hit, [3:1] way, [5:4] line_state, [6] l2_read,
   // [7] l2_read_for_ownership, [8] l2_write_through, [9] l2_write_back,
   // [10] snoop_data_return, [42:11] read_total, [74:43] write_total,
   // [106:75] hit_total, [138:107] miss_total, [143:139] zero
   logic [143:0] rsp_tdata;

   // Model of the tag store.
   logic [TAG_W-1:0] line_tag    [WAYS_DEF];
   bit               line_filled [WAYS_DEF];
   mesi_type         line_mesi   [WAYS_DEF];
   logic [7:0]       line_age    [WAYS_DEF];
   logic [31:0]      reads_seen  = '0;
   logic [31:0]      writes_seen = '0;
   logic [31:0]      hits_seen   = '0;
   logic [31:0]      misses_seen = '0;

   access_item_type  pending_accesses [$];
   rsp_type          due_responses    [$];
   access_item_type  next_access;
   rsp_type          seen_rsp;
   rsp_type          due_rsp;
   logic [TAG_W-1:0] tag_pool [POOL_SIZE];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int rsp_count      = 0;
   int mismatches     = 0;

   mesi_lru_data_cache_tags_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < WAYS_DEF; i++) begin
         line_tag[i]    = '0;
         line_filled[i] = 1'b0;
         line_mesi[i]   = MESI_I;
         line_age[i]    = '0;
      end
   end

   // Marks way w as most recently used: every way no older than it ages by one.
   function automatic void touch_way(input int w);
      logic [7:0] pivot;
      pivot = line_age[w];
      for (int i = 0; i < WAYS_DEF; i++)
         if (line_age[i] <= pivot)
            line_age[i] = line_age[i] + 8'd1;
      line_age[w] = '0;
   endfunction

   function automatic rsp_type cache_access(input mode_type mode, input logic [31:0] address);
      rsp_type          r;
      logic [TAG_W-1:0] lookup_tag;
      int               hit_way;
      int               victim;
      bit               was_unfilled;
      r          = '0;
      lookup_tag = address[31:TAG_SHIFT];
      hit_way    = -1;
      victim     = -1;
      was_unfilled = 1'b0;
      for (int i = WAYS_DEF - 1; i >= 0; i--)
         if (line_filled[i] && line_tag[i] == lookup_tag)
            hit_way = i;

      if (mode == MODE_READ || mode == MODE_WRITE) begin
         if (mode == MODE_WRITE)
            writes_seen = writes_seen + 1;
         else
            reads_seen = reads_seen + 1;
         if (hit_way >= 0) begin
            hits_seen = hits_seen + 1;
            r.hit     = 1'b1;
            victim    = hit_way;
            if (mode == MODE_WRITE)
               r.line_state = (line_mesi[hit_way] == MESI_M || line_mesi[hit_way] == MESI_E)
                              ? MESI_M : MESI_E;
            else
               r.line_state = (line_mesi[hit_way] == MESI_M) ? MESI_M : MESI_S;
         end else begin
            misses_seen = misses_seen + 1;
            for (int i = 0; i < WAYS_DEF; i++)
               if (victim < 0 && !line_filled[i]) begin
                  victim       = i;
                  was_unfilled = 1'b1;
               end
            for (int i = 0; i < WAYS_DEF; i++)
               if (victim < 0 && line_mesi[i] == MESI_I)
                  victim = i;
            if (victim < 0) begin
               // Filled ways hold distinct ages, so an oldest way exists;
               // way 0 is only the fallback.
               for (int i = 0; i < WAYS_DEF; i++)
                  if (victim < 0 && line_age[i] == WAYS_DEF - 1)
                     victim = i;
               if (victim < 0)
                  victim = 0;
               r.l2_write_back = (mode == MODE_WRITE);
            end
            if (mode == MODE_WRITE) begin
               r.line_state            = MESI_M;
               r.l2_write_through      = was_unfilled;
               r.l2_read_for_ownership = !was_unfilled;
            end else begin
               r.line_state = MESI_E;
               r.l2_read    = 1'b1;
            end
            line_tag[victim]    = lookup_tag;
            line_filled[victim] = 1'b1;
         end
         r.way             = 3'(victim);
         line_mesi[victim] = r.line_state;
         touch_way(victim);
      end else if (hit_way >= 0) begin
         r.hit               = 1'b1;
         r.way               = 3'(hit_way);
         r.snoop_data_return = (mode == MODE_SNOOP && line_mesi[hit_way] != MESI_I);
         line_mesi[hit_way]  = MESI_I;
         r.line_state        = MESI_I;
      end

      r.read_total  = reads_seen;
      r.write_total = writes_seen;
      r.hit_total   = hits_seen;
      r.miss_total  = misses_seen;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d: %s expected 0x%0h, got 0x%0h", rsp_count, name, want, got);
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            due_responses.push_back(cache_access(mode_type'(req_tuser), req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_access = pending_accesses.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_access.address;
               req_tuser  <= next_access.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and sink.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (due_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with nothing outstanding: 0x%0h",
                           rsp_count, rsp_tdata);
            end else begin
               due_rsp = due_responses.pop_front();
               check_field("hit", seen_rsp.hit, due_rsp.hit);
               check_field("way", seen_rsp.way, due_rsp.way);
               check_field("line_state", seen_rsp.line_state, due_rsp.line_state);
               check_field("l2_read", seen_rsp.l2_read, due_rsp.l2_read);
               check_field("l2_read_for_ownership", seen_rsp.l2_read_for_ownership,
                           due_rsp.l2_read_for_ownership);
               check_field("l2_write_through", seen_rsp.l2_write_through,
                           due_rsp.l2_write_through);
               check_field("l2_write_back", seen_rsp.l2_write_back, due_rsp.l2_write_back);
               check_field("snoop_data_return", seen_rsp.snoop_data_return,
                           due_rsp.snoop_data_return);
               check_field("read_total", seen_rsp.read_total, due_rsp.read_total);
               check_field("write_total", seen_rsp.write_total, due_rsp.write_total);
               check_field("hit_total", seen_rsp.hit_total, due_rsp.hit_total);
               check_field("miss_total", seen_rsp.miss_total, due_rsp.miss_total);
            end
            rsp_count++;
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** mesi_lru_data_cache_tags_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_access(input mode_type mode, input logic [31:0] address);
      access_item_type a;
      a.mode    = mode;
      a.address = address;
      pending_accesses.push_back(a);
   endtask

   // Mostly a small pool of tags so that hits, invalidated lines and LRU
   // evictions are frequent; the rest are fully random addresses.
   task automatic push_random_access();
      int          pick;
      mode_type    mode;
      logic [31:0] address;
      pick = $urandom_range(99);
      if (pick < 40)
         mode = MODE_READ;
      else if (pick < 75)
         mode = MODE_WRITE;
      else if (pick < 87)
         mode = MODE_INVALIDATE;
      else
         mode = MODE_SNOOP;
      address = $urandom;
      if ($urandom_range(9) != 0)
         address[31:TAG_SHIFT] = tag_pool[$urandom_range(POOL_SIZE - 1)];
      push_access(mode, address);
   endtask

   task automatic drain();
      while (pending_accesses.size() != 0 || req_tvalid || due_responses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input bit with_hold);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < POOL_SIZE; i++)
         tag_pool[i] = $urandom;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      repeat (PHASE_ACCESSES) push_random_access();
      if (with_hold) begin
         // Sink holds off while the source keeps offering, so the block backs up.
         while (pending_accesses.size() > PHASE_ACCESSES / 2)
            @(negedge clock);
         hold_requests++;
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Tag zero is a real tag; the filled flag decides emptiness.
      push_access(MODE_READ, 32'h0000_0000);
      push_access(MODE_READ, 32'h000F_FFFF);
      push_access(MODE_WRITE, 32'hFFFF_FFFF);
      push_access(MODE_WRITE, 32'hFFF0_0000);
      push_access(MODE_SNOOP, 32'hFFF1_2345);
      // Snoop and read on a line already invalid.
      push_access(MODE_SNOOP, 32'hFFF0_0000);
      push_access(MODE_READ, 32'hFFF0_0040);
      push_access(MODE_WRITE, 32'hFFF0_0000);
      push_access(MODE_WRITE, 32'hFFF0_0000);
      push_access(MODE_INVALIDATE, 32'h0000_0000);
      push_access(MODE_WRITE, 32'h000A_BCDE);
      push_access(MODE_INVALIDATE, 32'h1230_0000);
      push_access(MODE_SNOOP, 32'h4560_0000);
      push_access(MODE_WRITE, 32'h1110_0000);
      push_access(MODE_WRITE, 32'h2220_0000);
      push_access(MODE_WRITE, 32'h3330_0000);
      push_access(MODE_WRITE, 32'h4440_0000);
      push_access(MODE_WRITE, 32'h5550_0000);
      push_access(MODE_WRITE, 32'h6660_0000);
      // All ways filled: first an invalid victim, then LRU evictions.
      push_access(MODE_INVALIDATE, 32'h3330_0000);
      push_access(MODE_WRITE, 32'h7770_0000);
      push_access(MODE_READ, 32'h8880_0000);
      push_access(MODE_WRITE, 32'h9990_0000);
      push_access(MODE_READ, 32'h9990_0000);
      push_access(MODE_SNOOP, 32'h9990_0000);
      drain();

      run_phase(0, 0, 1'b1);
      run_phase(53, 0, 1'b0);
      run_phase(0, 53, 1'b0);
      run_phase(20, 20, 1'b0);

      if (mismatches == 0 && due_responses.size() == 0)
         $display("** mesi_lru_data_cache_tags_top: PASSED **");
      else
         $display("** mesi_lru_data_cache_tags_top: FAILED **");
      $finish;
   end

endmodule
